// ----- sv/ular_pkg.sv -----
// Shared types and constants for the line assembler ring.
// Used by the controller, the datapath and the top level; depends on nothing.
package ular_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_BYTE  = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Characters that end a line
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic receive;
    logic read;
    logic clear;
    logic issue;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic read_go;
    logic issue_last;
  } dp_sts_t;

endpackage

// ----- sv/ular_ctrl.sv -----
// Controller of the line assembler ring: accepts items and sequences reads.
// Depends on ular_pkg.
module ular_ctrl
  import ular_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] operation,
  input  dp_sts_t    sts,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    cmd.receive = accept && (operation == OP_RECEIVE);
    cmd.read    = accept && (operation == OP_READ);
    cmd.clear   = accept && (operation == OP_CLEAR);
    cmd.issue   = (state_r == S_READ);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.read && sts.read_go) state_nxt = S_READ;
      end
      S_READ: begin
        if (sts.issue_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/ular_dp.sv -----
// Datapath of the line assembler ring: line store, slot table, pointers
// and result registers. Depends on ular_pkg.
module ular_dp
  import ular_pkg::*;
#(
  parameter int LINES      = 8,
  parameter int LINE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  input  logic [7:0] rx_byte,
  input  logic [6:0] read_limit,
  output dp_sts_t    sts,
  output logic       out_strobe,
  output logic [1:0] out_status,
  output logic [7:0] out_byte,
  output logic [6:0] out_line_length,
  output logic       out_last
);

  localparam int SLOT_W = $clog2(LINES);
  localparam int CNT_W  = $clog2(LINE_BYTES);
  localparam int ADDR_W = SLOT_W + CNT_W;
  localparam int DEPTH  = LINES << CNT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINES - 1);
  localparam logic [CNT_W-1:0]  CUT_LEN   = CNT_W'(LINE_BYTES - 1);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        mem_q_r;

  logic [SLOT_W-1:0] ws_r, rs_r;
  logic [CNT_W-1:0]  wc_r;
  logic              prev_cr_r;
  logic [LINES-1:0]  used_r;
  logic [CNT_W-1:0]  len_r [LINES];

  logic [SLOT_W-1:0] rd_slot_r;
  logic [CNT_W-1:0]  rd_n_r, rd_len_r, idx_r;

  logic              out_vld_r, out_last_r;
  logic [1:0]        out_status_r;
  logic [6:0]        out_len_r;

  // Receive decode
  logic              line_start, drop_byte, reuse, term, cut, keep;
  logic [SLOT_W-1:0] tgt, tgt_prev, tgt_next;
  logic [CNT_W-1:0]  wc_inc, term_len;

  // Read decode
  logic              rd_hit;
  logic [CNT_W-1:0]  rd_len;
  logic [6:0]        rd_len_x;
  logic [CNT_W-1:0]  rd_n;
  logic [SLOT_W-1:0] rs_next;

  always_comb begin
    line_start = (wc_r == '0);
    drop_byte  = line_start && (rx_byte == CHAR_CLOSE);
    keep       = cmd.receive && !drop_byte;
    tgt_prev   = (ws_r == '0) ? LAST_SLOT : ws_r - 1'b1;
    reuse      = line_start && used_r[ws_r];
    tgt        = reuse ? tgt_prev : ws_r;
    tgt_next   = (tgt == LAST_SLOT) ? '0 : tgt + 1'b1;
    wc_inc     = wc_r + 1'b1;
    term_len   = wc_r - 1'b1;
    term       = (rx_byte == CHAR_CLOSE) ||
                 ((rx_byte == CHAR_LF) && !line_start && prev_cr_r);
    cut        = (wc_inc == CUT_LEN);
  end

  always_comb begin
    rd_hit   = used_r[rs_r];
    rd_len   = len_r[rs_r];
    rd_len_x = 7'(rd_len);
    rd_n     = (read_limit < rd_len_x) ? read_limit[CNT_W-1:0] : rd_len;
    rs_next  = (rs_r == LAST_SLOT) ? '0 : rs_r + 1'b1;
  end

  assign sts.read_go    = rd_hit && (read_limit != '0);
  assign sts.issue_last = (idx_r + 1'b1 == rd_n_r);

  // Line store: one write port for received bytes, one registered read port
  always_ff @(posedge clk) begin
    if (keep) mem[ADDR_W'({tgt, wc_r})] <= rx_byte;
    if (cmd.issue) mem_q_r <= mem[ADDR_W'({rd_slot_r, idx_r})];
  end

  // Write and read pointers, slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r      <= '0;
      wc_r      <= '0;
      rs_r      <= '0;
      used_r    <= '0;
      prev_cr_r <= 1'b0;
    end else if (cmd.clear) begin
      ws_r   <= '0;
      wc_r   <= '0;
      rs_r   <= '0;
      used_r <= '0;
    end else if (keep) begin
      prev_cr_r <= (rx_byte == CHAR_CR);
      if (term) begin
        used_r[tgt] <= (term_len != '0);
        wc_r        <= '0;
        ws_r        <= tgt_next;
      end else if (cut) begin
        used_r[tgt] <= 1'b1;
        wc_r        <= '0;
        ws_r        <= tgt_next;
      end else begin
        if (reuse) used_r[tgt] <= 1'b0;
        wc_r <= wc_inc;
        ws_r <= tgt;
      end
    end else if (cmd.read && rd_hit) begin
      used_r[rs_r] <= 1'b0;
      rs_r         <= rs_next;
    end
  end

  // Line lengths: meaningful only where the slot is marked used
  always_ff @(posedge clk) begin
    if (keep && term) begin
      len_r[tgt] <= term_len;
    end else if (keep && cut) begin
      len_r[tgt] <= wc_inc;
    end
  end

  // Read sequencing
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_slot_r <= rs_r;
      rd_n_r    <= rd_n;
      rd_len_r  <= rd_len;
      idx_r     <= '0;
    end else if (cmd.issue) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cmd.issue || (cmd.read && !sts.read_go);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      out_status_r <= ST_BYTE;
      out_len_r    <= 7'(rd_len_r);
      out_last_r   <= sts.issue_last;
    end else if (cmd.read) begin
      out_status_r <= rd_hit ? ST_EMPTY : ST_NONE;
      out_len_r    <= rd_hit ? rd_len_x : 7'd0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_strobe      = out_vld_r;
  assign out_status      = out_status_r;
  assign out_byte        = (out_status_r == ST_BYTE) ? mem_q_r : 8'd0;
  assign out_line_length = out_len_r;
  assign out_last        = out_last_r;

endmodule

// ----- sv/uart_line_assembler_ring.sv -----
// Top level of the serial receive line assembler ring.
// Depends on ular_pkg, ular_ctrl and ular_dp.
//
// Usage:
//   Issue an item by raising start with in_operation, in_rx_byte and
//   in_read_limit while busy is low; the item is taken at that clock edge.
//   Receive (operation 0) stores one byte into the current line and gives
//   no result; bytes may arrive on every cycle while busy is low.
//   A line closes on CR followed by LF, or on ')', and is cut off once it
//   holds LINE_BYTES-1 bytes. If a new line would start in an unread slot,
//   the newest finished line is dropped and its slot reused.
//   Read (operation 1) returns the oldest line: one result per byte, up to
//   in_read_limit bytes, with out_last on the final one, then frees the slot.
//   An empty ring gives one "no line" result; a zero limit gives one
//   "no bytes copied" result. Clear (operation 2) empties the ring.
//   A "no line" or "no bytes copied" result appears in the cycle after the
//   read is taken; byte results follow once the controller is in its read
//   state, one per cycle, paced by the registered read port of the line store.
//   busy stays high while the bytes of a read are issued and is low otherwise.
//   Each result sits on the out_ ports for one cycle with out_strobe high;
//   the receiver cannot stall. Reset (synchronous, rst_n low) empties the
//   ring and drops any read in progress; the line store is not cleared.
module uart_line_assembler_ring
  import ular_pkg::*;
#(
  parameter int LINES      = 8,
  parameter int LINE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_rx_byte,
  input  logic [6:0] in_read_limit,
  output logic       out_strobe,
  output logic [1:0] out_status,
  output logic [7:0] out_byte,
  output logic [6:0] out_line_length,
  output logic       out_last
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Decode items and step through the bytes of a read
  ular_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_operation),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Hold the lines, the slot pointers and the result registers
  ular_dp #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .rx_byte         (in_rx_byte),
    .read_limit      (in_read_limit),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_byte        (out_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for uart_line_assembler_ring: directed and random items
// against a line ring predictor held in a small scoreboard class.
// Depends on ular_pkg and the uart_line_assembler_ring RTL.
module tb
  import ular_pkg::*;
();

  localparam int LINES      = 8;
  localparam int LINE_BYTES = 32;
  localparam int ITEM_GOAL  = 310;
  localparam int STALL_LIMIT = 1000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] status;
    logic [7:0] data;
    logic [6:0] line_len;
    logic       is_last;
  } ring_result_t;

  // Line ring predictor plus the queue of results it still expects.
  class line_ring_scoreboard;
    logic [7:0]   store[LINES*LINE_BYTES];
    logic [5:0]   lengths[LINES];
    int unsigned  wr_slot, wr_count, rd_slot;
    ring_result_t expected_q[$];
    int unsigned  mismatches, results_seen;

    function new();
      foreach (store[i]) store[i] = '0;
      clear_ring();
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void clear_ring();
      foreach (lengths[i]) lengths[i] = '0;
      wr_slot = 0;
      wr_count = 0;
      rd_slot = 0;
    endfunction

    function int unsigned next_slot(int unsigned s);
      return (s >= LINES - 1) ? 0 : s + 1;
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned ws, wc;
      logic        closes;
      ws = wr_slot;
      wc = wr_count;
      if (wc == 0) begin
        if (b == CHAR_CLOSE) return;
        // reuse the newest finished line's slot when the ring is full
        if (lengths[ws] != '0) begin
          ws = (ws == 0) ? LINES - 1 : ws - 1;
          lengths[ws] = '0;
        end
      end
      if (wc >= LINE_BYTES) wc = LINE_BYTES - 1;
      store[ws*LINE_BYTES + wc] = b;
      wc++;
      closes = (b == CHAR_CLOSE) ||
               (b == CHAR_LF && wc >= 2 && store[ws*LINE_BYTES + wc - 2] == CHAR_CR);
      if (closes) begin
        lengths[ws] = 6'(wc - 2);
        wc = 0;
        ws = next_slot(ws);
      end else if (wc >= LINE_BYTES - 1) begin
        lengths[ws] = 6'(wc);
        wc = 0;
        ws = next_slot(ws);
      end
      wr_slot = ws;
      wr_count = wc;
    endfunction

    function void read_oldest(logic [6:0] limit);
      int unsigned  len, n;
      ring_result_t r;
      len = lengths[rd_slot];
      if (len == 0) begin
        r = '{ST_NONE, 8'h00, 7'd0, 1'b1};
        expected_q.push_back(r);
        return;
      end
      n = (limit < len) ? limit : len;
      if (n == 0) begin
        r = '{ST_EMPTY, 8'h00, 7'(len), 1'b1};
        expected_q.push_back(r);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          r = '{ST_BYTE, store[rd_slot*LINE_BYTES + i], 7'(len), (i + 1 == n)};
          expected_q.push_back(r);
        end
      end
      lengths[rd_slot] = '0;
      rd_slot = next_slot(rd_slot);
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] b, logic [6:0] limit);
      case (op)
        OP_RECEIVE: take_byte(b);
        OP_READ:    read_oldest(limit);
        OP_CLEAR:   clear_ring();
        default: ;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [1:0] st, logic [7:0] b, logic [6:0] len, logic lst);
      ring_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d byte=%02h len=%0d last=%0b",
                         st, b, len, lst));
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status || b !== want.data || len !== want.line_len ||
          lst !== want.is_last)
        report($sformatf("result %0d: got status=%0d byte=%02h len=%0d last=%0b, want %0d %02h %0d %0b",
                         results_seen, st, b, len, lst,
                         want.status, want.data, want.line_len, want.is_last));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // Clock, reset and block inputs; every input starts at a known value.
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_operation = OP_RECEIVE;
  logic [7:0] in_rx_byte = 8'h00;
  logic [6:0] in_read_limit = 7'd0;
  logic       busy;
  logic       out_strobe;
  logic [1:0] out_status;
  logic [7:0] out_byte;
  logic [6:0] out_line_length;
  logic       out_last;

  line_ring_scoreboard ring = new();
  int unsigned items_done = 0;
  int unsigned reads_done = 0;
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;

  always #10 clk = ~clk;

  uart_line_assembler_ring #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_rx_byte      (in_rx_byte),
    .in_read_limit   (in_read_limit),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_byte        (out_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  // Present one item and hold it until the block takes it. Start stays high
  // afterwards; the next call either keeps it high or drops it for a gap.
  task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                           input logic [6:0] limit);
    // each cycle before the item stays idle with the phase's odds
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_rx_byte    <= b;
    in_read_limit <= limit;
    // busy is sampled as it was before the edge, so this edge took the item
    do @(posedge clk); while (busy !== 1'b0);
    ring.note_item(op, b, limit);
    if (op != OP_UNUSED) items_done++;
    if (op == OP_READ) reads_done++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_RECEIVE, b, 7'($urandom));
  endtask

  task automatic send_read(input logic [6:0] limit);
    send_item(OP_READ, 8'($urandom), limit);
  endtask

  // Mostly everyday limits, with zero and the top of the 7-bit range mixed in.
  function automatic logic [6:0] pick_limit();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 7'd0;
    if (sel == 1) return 7'($urandom_range(64, 127));
    return 7'($urandom_range(1, 40));
  endfunction

  // Send one line with random content: short most of the time, sometimes long
  // enough to be cut off, closed by CR LF, by ')' or left open.
  task automatic send_line();
    int unsigned body_len, ending;
    logic [7:0]  b, prev;
    body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(26, 34) : $urandom_range(0, 10);
    ending = $urandom_range(0, 3);
    prev = 8'h00;
    for (int unsigned i = 0; i < body_len; i++) begin
      b = 8'($urandom);
      // keep the body free of anything that would close the line early
      if (b == CHAR_CLOSE || (prev == CHAR_CR && b == CHAR_LF)) b = 8'h41;
      send_byte(b);
      prev = b;
    end
    case (ending)
      0, 1: begin
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
      2: send_byte(CHAR_CLOSE);
      default: ;
    endcase
  endtask

  // Check every result on the cycle it is shown.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      ring.check_result(out_status, out_byte, out_line_length, out_last);
  end

  // Count cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if ((start && busy === 1'b0 && rst_n) || out_strobe === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results still expected",
               STALL_LIMIT, ring.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase, pick, read_pct;
    int unsigned sel;
    logic [7:0]  noise;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty ring, dropped leading ')', leading LF kept, byte extremes,
    // empty closed line, zero and oversized limits, clear and the unused code.
    send_read(7'd5);
    send_byte(CHAR_CLOSE);
    send_byte(CHAR_LF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(8'h61);
    send_byte(CHAR_CLOSE);
    send_read(7'd64);
    send_read(7'd1);
    send_item(OP_CLEAR, 8'hFF, 7'd127);
    send_byte(8'h51);
    send_byte(8'h52);
    send_byte(CHAR_CLOSE);
    send_read(7'd0);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(CHAR_CLOSE);
    send_read(7'd127);
    send_item(OP_UNUSED, 8'hFF, 7'd127);
    send_read(7'd64);
    send_item(OP_CLEAR, 8'h00, 7'd0);

    // Random: four phases; the write-heavy ones fill the ring and force reuse.
    while (items_done < ITEM_GOAL) begin
      phase = (items_done * 4) / ITEM_GOAL;
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 0;
        default: idle_pct = 18;
      endcase
      read_pct = (phase % 2 == 1) ? 18 : 35;
      pick = $urandom_range(0, 99);
      if (pick < read_pct) begin
        send_read(pick_limit());
      end else if (pick < read_pct + 3) begin
        send_item(OP_CLEAR, 8'($urandom), 7'($urandom));
      end else if (pick < read_pct + 5) begin
        send_item(OP_UNUSED, 8'($urandom), 7'($urandom));
      end else if (pick < read_pct + 15) begin
        // stray bytes, terminators among them
        sel = $urandom_range(0, 3);
        noise = (sel == 0) ? CHAR_CR : (sel == 1) ? CHAR_LF :
                (sel == 2) ? CHAR_CLOSE : 8'($urandom);
        send_byte(noise);
      end else begin
        send_line();
      end
    end

    // Drain: drop start, wait for every expected result, then a short tail.
    start <= 1'b0;
    while (ring.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d items accepted, %0d of them reads, %0d results checked",
             items_done, reads_done, ring.results_seen);
    $display("     %0d mismatches found", ring.mismatches);
    if (ring.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
